@@ sv/jsu_pkg.sv @@
package jsu_pkg;

  localparam int unsigned GRP_MAX = 3;
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [1:0] STATUS_DATA   = 2'd0;
  localparam logic [1:0] STATUS_CLOSED = 2'd1;
  localparam logic [1:0] STATUS_UNTERM = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [15:0] UTF_LIM1  = 16'h0080;
  localparam logic [15:0] UTF_LIM2  = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [5:0]  UTF_MASK  = 6'h3F;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef res_t [GRP_MAX-1:0] grp_t;

  // One decoded item: number of results and the results themselves.
  typedef struct packed {
    logic [1:0] n;
    grp_t       res;
  } push_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ sv/jsu_decode.sv @@
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       payload_end_i,
  output push_t      push_o
);

  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_ESC      = 3'd1;
  localparam logic [2:0] MODE_HEX0     = 3'd2;
  localparam logic [2:0] MODE_HEX_LAST = 3'd5;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] hv_q, hv_d;
  logic        still_q, still_d;

  logic [4:0]  hd;
  logic [15:0] hv_new;
  logic [7:0]  esc_byte;

  function automatic res_t mk(input logic [7:0] d, input logic [1:0] s, input logic l);
    res_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  assign hd = hex_digit(in_byte_i);

  always_comb begin
    unique case (in_byte_i)
      8'h6E:   esc_byte = 8'h0A;
      8'h74:   esc_byte = 8'h09;
      8'h72:   esc_byte = 8'h0D;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0C;
      default: esc_byte = in_byte_i;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    hv_d    = hv_q;
    still_d = still_q;
    hv_new  = hv_q;
    push_o  = '0;
    if (payload_end_i) begin
      if (mode_q == MODE_ESC) begin
        push_o.n      = 2'd2;
        push_o.res[0] = mk(CH_BSLASH, STATUS_DATA, 1'b0);
        push_o.res[1] = mk(8'h00, STATUS_UNTERM, 1'b1);
      end else begin
        push_o.n      = 2'd1;
        push_o.res[0] = mk(8'h00, STATUS_UNTERM, 1'b1);
      end
      mode_d  = MODE_NORMAL;
      hv_d    = '0;
      still_d = 1'b1;
    end else if (mode_q == MODE_NORMAL) begin
      if (in_byte_i == CH_QUOTE) begin
        push_o.n      = 2'd1;
        push_o.res[0] = mk(8'h00, STATUS_CLOSED, 1'b1);
        hv_d          = '0;
        still_d       = 1'b1;
      end else if (in_byte_i == CH_BSLASH) begin
        mode_d = MODE_ESC;
      end else begin
        push_o.n      = 2'd1;
        push_o.res[0] = mk(in_byte_i, STATUS_DATA, 1'b1);
      end
    end else if (mode_q == MODE_ESC) begin
      if (in_byte_i == 8'h75) begin
        mode_d  = MODE_HEX0;
        hv_d    = '0;
        still_d = 1'b1;
      end else begin
        mode_d        = MODE_NORMAL;
        push_o.n      = 2'd1;
        push_o.res[0] = mk(esc_byte, STATUS_DATA, 1'b1);
      end
    end else begin
      // Gather leading hex digits; the first non-hex byte stops the value.
      if (still_q && hd[4]) begin
        hv_new = {hv_q[11:0], hd[3:0]};
      end else begin
        still_d = 1'b0;
      end
      hv_d = hv_new;
      if (mode_q >= MODE_HEX_LAST) begin
        if (hv_new < UTF_LIM1) begin
          push_o.n      = 2'd1;
          push_o.res[0] = mk(hv_new[7:0], STATUS_DATA, 1'b1);
        end else if (hv_new < UTF_LIM2) begin
          push_o.n      = 2'd2;
          push_o.res[0] = mk(UTF_LEAD2 | {3'b000, hv_new[10:6]}, STATUS_DATA, 1'b0);
          push_o.res[1] = mk(UTF_CONT | {2'b00, hv_new[5:0] & UTF_MASK}, STATUS_DATA, 1'b1);
        end else begin
          push_o.n      = 2'd3;
          push_o.res[0] = mk(UTF_LEAD3 | {4'b0000, hv_new[15:12]}, STATUS_DATA, 1'b0);
          push_o.res[1] = mk(UTF_CONT | {2'b00, hv_new[11:6] & UTF_MASK}, STATUS_DATA, 1'b0);
          push_o.res[2] = mk(UTF_CONT | {2'b00, hv_new[5:0] & UTF_MASK}, STATUS_DATA, 1'b1);
        end
        mode_d  = MODE_NORMAL;
        hv_d    = '0;
        still_d = 1'b1;
      end else begin
        mode_d = mode_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      hv_q    <= '0;
      still_q <= 1'b1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      hv_q    <= hv_d;
      still_q <= still_d;
    end
  end

  property p_mode_range;
    @(posedge clk_i) disable iff (!rst_ni) mode_q <= MODE_HEX_LAST;
  endproperty
  a_mode_range: assert property (p_mode_range) else $error("escape mode out of range");

  property p_still_in_hex;
    @(posedge clk_i) disable iff (!rst_ni) (mode_q < MODE_HEX0) |-> still_q;
  endproperty
  a_still_in_hex: assert property (p_still_in_hex) else $error("digit flag stale outside \\u");

  property p_end_clears;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept_i && payload_end_i) |=> (mode_q == MODE_NORMAL && hv_q == 16'h0000);
  endproperty
  a_end_clears: assert property (p_end_clears) else $error("state not cleared at payload end");

endmodule

@@ sv/jsu_queue.sv @@
module jsu_queue import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  push_t      push_data_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       head_o
);

  res_t [Q_DEPTH-1:0] ent_q, ent_d;
  res_t [Q_DEPTH-1:0] sh;
  logic [2:0]         cnt_q, cnt_d;
  logic [2:0]         base;
  logic [2:0]         off;
  logic               pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = ent_q[0];
  assign base        = cnt_q - {2'b00, pop};
  // Room for a full group of three once the head leaves.
  assign room_o      = (base <= 3'(Q_DEPTH - GRP_MAX));

  always_comb begin
    ent_d = ent_q;
    for (int i = 0; i < Q_DEPTH; i++) begin
      sh[i] = ent_q[i];
      if (pop && i < Q_DEPTH - 1) begin
        sh[i] = ent_q[i + 1];
      end
    end
    for (int i = 0; i < Q_DEPTH; i++) begin
      off      = 3'(i) - base;
      ent_d[i] = sh[i];
      if (push_i && 3'(i) >= base && off < {1'b0, push_data_i.n}) begin
        unique case (off[1:0])
          2'd0:    ent_d[i] = push_data_i.res[0];
          2'd1:    ent_d[i] = push_data_i.res[1];
          2'd2:    ent_d[i] = push_data_i.res[2];
          default: ent_d[i] = sh[i];
        endcase
      end
    end
    cnt_d = base + (push_i ? {1'b0, push_data_i.n} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Q_DEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("result queue overfilled");

  property p_status_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && head_o.status != STATUS_DATA) |-> head_o.last;
  endproperty
  a_status_last: assert property (p_status_last) else $error("status result not marked last");

  property p_idle_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      (!out_valid_o && !push_i) |=> !out_valid_o;
  endproperty
  a_idle_empty: assert property (p_idle_empty) else $error("result appeared without an item");

endmodule

@@ sv/json_string_unescaper.sv @@
// An item's first result shows in the cycle after it is accepted, if no earlier result waits.
// Throughput: one item per cycle; results leave the four-entry queue one a cycle while out_ready_i
// is high, and the input stalls while fewer than three entries would be free, so a \u escape giving
// three UTF-8 bytes stalls the input even with the output always ready; two bytes cause no stall.
// A backslash, the u after it and the first three \u digits give no result.
// Reset (rst_ni low, asynchronous): escape state returns to normal and the queue empties.
module json_string_unescaper import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       payload_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic  accept;
  push_t push;
  res_t  head;

  assign accept = in_valid_i && in_ready_o;

  jsu_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .payload_end_i (payload_end_i),
    .push_o        (push)
  );

  jsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_byte_o = head.data;
  assign status_o   = head.status;
  assign last_o     = head.last;

endmodule
